// ----- hw/rtl/pbs_pkg.sv -----
// Shared constants and types of the bounded packet buffer scheduler.
package pbs_pkg;

  localparam int DEPTH  = 64;
  localparam int TIME_W = 32;
  localparam int PT_W   = 16;
  localparam int CAP_W  = 7;
  localparam int OCC_W  = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
  localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(DEPTH);

  typedef logic [TIME_W-1:0] time_t;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HOLD = 2'b10
  } state_t;

  // Commands from the controller to the chain
  typedef struct packed {
    logic  pop;
    logic  push;
    time_t push_value;
  } chain_ctrl_t;

  // Status from the chain to the controller
  typedef struct packed {
    time_t            head;
    logic [OCC_W-1:0] occ;
  } chain_stat_t;

endpackage

// ----- hw/rtl/pbs_cell.sv -----
// One cell of the finish-time chain: holds one entry, shifts towards the head.
module pbs_cell (
  input  logic          clk,
  input  logic          shift,
  input  logic          load,
  input  pbs_pkg::time_t neighbour,
  input  pbs_pkg::time_t load_value,
  output pbs_pkg::time_t value
);

  // Take the neighbour's entry on a pop, the new finish time on a push
  always_ff @(posedge clk) begin
    if (shift) begin
      value <= neighbour;
    end else if (load) begin
      value <= load_value;
    end
  end

endmodule

// ----- hw/rtl/pbs_chain.sv -----
// Row of cells holding the finish times in order, head at cell zero.
module pbs_chain (
  input  logic                 clk,
  input  logic                 rst,
  input  pbs_pkg::chain_ctrl_t ctrl,
  output pbs_pkg::chain_stat_t stat
);

  logic [pbs_pkg::OCC_W-1:0] occ;
  pbs_pkg::time_t            cell_value [pbs_pkg::DEPTH];

  // Track how many cells hold an entry
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (ctrl.pop) begin
      occ <= occ - pbs_pkg::OCC_W'(1);
    end else if (ctrl.push) begin
      occ <= occ + pbs_pkg::OCC_W'(1);
    end
  end

  // Build the row; the first free cell takes a pushed entry
  for (genvar i = 0; i < pbs_pkg::DEPTH; i++) begin : g_cell
    pbs_pkg::time_t nb;
    logic           sel;

    if (i == pbs_pkg::DEPTH - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_value[i+1];
    end

    assign sel = (occ == pbs_pkg::OCC_W'(i));

    pbs_cell u_cell (
      .clk        (clk),
      .shift      (ctrl.pop),
      .load       (ctrl.push & sel),
      .neighbour  (nb),
      .load_value (ctrl.push_value),
      .value      (cell_value[i])
    );
  end

  assign stat.head = cell_value[0];
  assign stat.occ  = occ;

endmodule

// ----- hw/rtl/bounded_packet_buffer_scheduler.sv -----
// Top level of the bounded packet buffer scheduler.
//
// Packets arrive as beats on the input channel (in_valid / in_ready) with an
// arrival time and a processing time. Each packet gives one result beat on
// the output channel (out_valid / out_ready): a drop flag and the start time.
// The finish times of held packets sit in a row of 64 cells, oldest first.
// A packet first retires every held entry whose finish time is at or before
// its arrival, one entry per cycle through the cell row, then is either
// dropped or pushed into the first free cell.
// The result is registered and shows in the cycle after the decision. One
// packet is worked on at a time; the next beat is taken as soon as the last
// one is decided, even while its result still waits. A stalled receiver holds
// the decision of the following packet until the output register is free.
// buffer_capacity is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, since the block does not enforce this.
// Reset empties the buffer, clears the last finish time and sets the
// capacity to 64.
module bounded_packet_buffer_scheduler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [pbs_pkg::CAP_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pbs_pkg::TIME_W-1:0]  arrival_stamp,
  input  logic [pbs_pkg::PT_W-1:0]    service_len,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        dropped,
  output logic [pbs_pkg::TIME_W-1:0]  service_start
);

  pbs_pkg::state_t          state, state_next;
  logic [pbs_pkg::CAP_W-1:0] buffer_capacity;
  logic [pbs_pkg::CAP_W-1:0] cap_eff;
  pbs_pkg::time_t           arr_q;
  logic [pbs_pkg::PT_W-1:0]  pt_q;
  pbs_pkg::time_t           last_finish;
  pbs_pkg::time_t           arr_cur, start_cur, finish_cur;
  logic [pbs_pkg::PT_W-1:0]  pt_cur;
  logic [pbs_pkg::TIME_W:0]  finish_sum;
  logic                     pending, pop_cond, out_free, decide, drop;
  pbs_pkg::chain_ctrl_t     ctrl;
  pbs_pkg::chain_stat_t     stat;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_capacity <= pbs_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      buffer_capacity <= cfg_wr_data;
    end
  end

  assign cap_eff = (buffer_capacity > pbs_pkg::CAP_LIMIT) ? pbs_pkg::CAP_LIMIT
                                                          : buffer_capacity;

  // Select the packet in work: the incoming beat when idle, else the held one
  assign in_ready = (state == pbs_pkg::ST_IDLE);
  assign arr_cur  = in_ready ? arrival_stamp : arr_q;
  assign pt_cur   = in_ready ? service_len : pt_q;
  assign pending  = (state == pbs_pkg::ST_HOLD) | in_valid;

  // Retire the head while it finishes by the arrival; otherwise decide once the result register is free
  assign pop_cond = (stat.occ != '0) && (stat.head <= arr_cur);
  assign out_free = ~out_valid | out_ready;
  assign decide   = pending & ~pop_cond & out_free;
  assign drop     = (stat.occ >= cap_eff);

  // Start and saturated finish time
  assign start_cur  = (stat.occ == '0) ? arr_cur : last_finish;
  assign finish_sum = {1'b0, start_cur} + {{(pbs_pkg::TIME_W+1-pbs_pkg::PT_W){1'b0}}, pt_cur};
  assign finish_cur = finish_sum[pbs_pkg::TIME_W] ? '1 : finish_sum[pbs_pkg::TIME_W-1:0];

  // Drive the chain
  assign ctrl.pop        = pending & pop_cond;
  assign ctrl.push       = decide & ~drop;
  assign ctrl.push_value = finish_cur;

  pbs_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (stat)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pbs_pkg::ST_IDLE: begin
        if (in_valid & ~decide) begin
          state_next = pbs_pkg::ST_HOLD;
        end
      end
      pbs_pkg::ST_HOLD: begin
        if (decide) begin
          state_next = pbs_pkg::ST_IDLE;
        end
      end
      default: state_next = pbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the accepted packet
  always_ff @(posedge clk) begin
    if (in_valid & in_ready) begin
      arr_q <= arrival_stamp;
      pt_q  <= service_len;
    end
  end

  // Remember the newest finish time
  always_ff @(posedge clk) begin
    if (rst) begin
      last_finish <= '0;
    end else if (ctrl.push) begin
      last_finish <= finish_cur;
    end
  end

  // Result register: load on a decision, drop the beat once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (decide) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide) begin
      dropped       <= drop;
      service_start <= drop ? '0 : start_cur;
    end
  end

endmodule

// ----- verif/bounded_packet_buffer_scheduler_test.sv -----
// Self-checking testbench for the bounded packet buffer scheduler.
`timescale 1ns / 100ps

module bounded_packet_buffer_scheduler_test;

  localparam pbs_pkg::time_t TIME_TOP = '1;

  typedef struct packed {
    logic           dropped;
    pbs_pkg::time_t service_start;
  } sched_result_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_wr_en;
  logic [pbs_pkg::CAP_W-1:0]  cfg_wr_data;
  logic                       in_valid;
  logic                       in_ready;
  pbs_pkg::time_t             arrival_stamp;
  logic [pbs_pkg::PT_W-1:0]   service_len;
  logic                       out_valid;
  logic                       out_ready;
  logic                       dropped;
  pbs_pkg::time_t             service_start;

  // Scheduler state as the testbench sees it
  pbs_pkg::time_t             held_finish[$];
  pbs_pkg::time_t             newest_finish;
  logic [pbs_pkg::CAP_W-1:0]  capacity_setting;
  sched_result_t              awaited_results[$];

  // Traffic shaping
  bit                         bursty;
  int                         burst_left;
  int                         stall_mode;
  int                         ready_tick;
  pbs_pkg::time_t             clock_now;
  int                         error_count;

  bounded_packet_buffer_scheduler dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .arrival_stamp (arrival_stamp),
    .service_len   (service_len),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .dropped       (dropped),
    .service_start (service_start)
  );

  always #6 clk = ~clk;

  // Retire finished packets, then drop or push the new one
  function automatic void schedule_packet(input pbs_pkg::time_t arrival,
                                          input logic [pbs_pkg::PT_W-1:0] ptime,
                                          output logic drop, output pbs_pkg::time_t start);
    int                         cap_eff;
    logic [pbs_pkg::TIME_W:0]   sum;
    pbs_pkg::time_t             finish;
    cap_eff = (capacity_setting > pbs_pkg::DEPTH) ? pbs_pkg::DEPTH
                                                  : int'(capacity_setting);
    while (held_finish.size() > 0 && held_finish[0] <= arrival)
      void'(held_finish.pop_front());
    if (held_finish.size() >= cap_eff) begin
      drop  = 1'b1;
      start = '0;
    end else begin
      drop   = 1'b0;
      start  = (held_finish.size() == 0) ? arrival : newest_finish;
      sum    = {1'b0, start} + ptime;
      finish = sum[pbs_pkg::TIME_W] ? TIME_TOP : sum[pbs_pkg::TIME_W-1:0];
      held_finish = {held_finish, finish};
      newest_finish = finish;
    end
  endfunction

  task automatic report_mismatch(input string what, input pbs_pkg::time_t got,
                                 input pbs_pkg::time_t want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Send one packet beat, idling between bursts when asked
  task automatic send_packet(input pbs_pkg::time_t arrival,
                             input logic [pbs_pkg::PT_W-1:0] ptime);
    int             gap;
    logic           drop;
    pbs_pkg::time_t start;
    sched_result_t  res;
    @(negedge clk);
    if (bursty && burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_valid      <= 1'b1;
    arrival_stamp <= arrival;
    service_len   <= ptime;
    do @(posedge clk); while (!in_ready);
    schedule_packet(arrival, ptime, drop, start);
    res.dropped       = drop;
    res.service_start = start;
    awaited_results = {awaited_results, res};
  endtask

  // Drop valid and hold until every result beat has come back
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the capacity register; only called while the block is idle
  task automatic write_capacity(input logic [pbs_pkg::CAP_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    capacity_setting = value;
  endtask

  // Flush every held packet with a drop at the top time, then pick a new time base
  task automatic rebase_time();
    write_capacity('0);
    send_packet(TIME_TOP, pbs_pkg::PT_W'($urandom));
    wait_all_results();
    clock_now = $urandom & 32'hFFFF_F000;
    if (clock_now > 32'hFFF0_0000) clock_now = 32'hFFF0_0000;
  endtask

  task automatic test_basic_timing();
    bursty     = 1'b1;
    stall_mode = 1;
    send_packet(32'd0, 16'd0);
    send_packet(32'd0, 16'd5);
    send_packet(32'd1, 16'hFFFF);
    send_packet(32'd2, 16'd3);
    send_packet(32'd3, 16'd0);
    // earlier arrival: retirement stops at the first later finish
    send_packet(32'd1, 16'd4);
    send_packet(32'd100000, 16'd7);
    wait_all_results();
  endtask

  task automatic test_finish_saturation();
    send_packet(32'hFFFF_FF00, 16'hFFFF);
    send_packet(32'hFFFF_FF01, 16'h0010);
    send_packet(TIME_TOP, 16'hFFFF);
    wait_all_results();
    rebase_time();
  endtask

  task automatic test_capacity_edges();
    int k;
    send_packet(clock_now, 16'd3);
    send_packet(clock_now + 1, 16'd3);
    wait_all_results();
    write_capacity(7'd1);
    send_packet(clock_now + 2, 16'd10);
    send_packet(clock_now + 3, 16'd1);
    send_packet(clock_now + 12, 16'd2);
    wait_all_results();
    // above the depth acts as the full depth
    write_capacity(7'd127);
    send_packet(clock_now + 20, 16'd50);
    send_packet(clock_now + 21, 16'd1);
    wait_all_results();
    write_capacity(7'd64);
    for (k = 0; k < 4; k++) send_packet(clock_now + 30, 16'd1000);
    wait_all_results();
    // lowered below occupancy: held packets stay, new ones drop until enough retire
    write_capacity(7'd2);
    send_packet(clock_now + 31, 16'd1);
    send_packet(clock_now + 9000, 16'd2);
    wait_all_results();
  endtask

  task automatic run_phase(input logic [pbs_pkg::CAP_W-1:0] cap, input bit rebase_first,
                           input int step_max, input int ptime_max, input int count,
                           input bit bursty_in, input int stall_in);
    int                         i;
    pbs_pkg::time_t             arrival;
    logic [pbs_pkg::PT_W-1:0]   ptime;
    if (rebase_first) rebase_time();
    bursty     = bursty_in;
    burst_left = 0;
    stall_mode = stall_in;
    write_capacity(cap);
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 31) == 0 && clock_now >= 3) begin
        arrival = clock_now - $urandom_range(1, 3);
      end else begin
        clock_now = clock_now + $urandom_range(0, step_max);
        arrival   = clock_now;
      end
      if ($urandom_range(0, 15) == 0) ptime = pbs_pkg::PT_W'($urandom);
      else ptime = pbs_pkg::PT_W'($urandom_range(0, ptime_max));
      send_packet(arrival, ptime);
    end
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    run_phase(7'd64, 1'b1, 8, 20, 200, 1'b1, 1);
    run_phase(7'd127, 1'b1, 1, 200, 150, 1'b0, 0);
    run_phase(7'd3, 1'b0, 10, 30, 150, 1'b1, 2);
    run_phase(7'd1, 1'b1, 5, 10, 120, 1'b1, 1);
    run_phase(7'd0, 1'b1, 3, 5, 40, 1'b0, 2);
    run_phase(pbs_pkg::CAP_W'($urandom_range(0, 127)), 1'b1, 20, 40, 200, 1'b1, 1);
    run_phase(7'd64, 1'b1, 40, 65535, 200, 1'b0, 0);
    run_phase(pbs_pkg::CAP_W'($urandom_range(0, 127)), 1'b1, 4, 8, 240, 1'b1, 2);
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    ready_tick = ready_tick + 1;
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_ready <= ((ready_tick % 11) < 6);
      end
    endcase
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result beat, service_start", service_start, '0);
      end else begin
        want = awaited_results.pop_front();
        if (dropped !== want.dropped)
          report_mismatch("dropped", pbs_pkg::time_t'(dropped),
                          pbs_pkg::time_t'(want.dropped));
        if (service_start !== want.service_start)
          report_mismatch("service_start", service_start, want.service_start);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_valid         = 1'b0;
    arrival_stamp    = '0;
    service_len      = '0;
    out_ready        = 1'b0;
    newest_finish    = '0;
    capacity_setting = pbs_pkg::CAP_RESET;
    bursty           = 1'b0;
    burst_left       = 0;
    stall_mode       = 0;
    ready_tick       = 0;
    clock_now        = '0;
    error_count      = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_timing();
    test_finish_saturation();
    test_capacity_edges();
    test_random_traffic();

    wait_all_results();
    repeat (20) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("results never delivered",
                      pbs_pkg::time_t'(awaited_results.size()), '0);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
